### src/double_ended_queue_defines.svh
// ---------------------------------------------------------------------------
// double_ended_queue_defines.svh
// assertion macros shared by the deque modules
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### src/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// types and constants of the double-ended queue
// ---------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_CAPACITY   = 16;
	localparam int DQ_DATA_WIDTH = 32;
	localparam int DQ_WORD_W     = 32;

	// request codes
	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} dq_req_t;

	// what every cell does on a clock edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_POP_BACK
	} dq_cell_op_t;

	typedef struct packed {
		dq_cell_op_t op;
		logic        ret_shift;
	} dq_cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_RETURN
	} dq_state_t;

endpackage

### src/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity deque of data words built as a chain of shifting cells
// ---------------------------------------------------------------------------
// The words live in a row of CAPACITY cells packed from cell zero: cell zero
// holds the front word, the last valid cell holds the back word. A push front
// shifts the whole row one cell back and drops the new word into cell zero,
// a pop front shifts the row one cell forward and hands out cell zero, and a
// push back fills the first free cell. After each of these the block takes
// the next request in the following cycle as long as the result register
// is free or being drained. A pop back launches the back word into a return
// path that runs beside the cells and moves one cell toward cell zero per
// cycle, so a pop back gives its result once the word reaches cell zero and
// takes no new request until then; the length of that walk is what sets the
// pop back rate. Every request gives one result: ok, the popped word (zero
// for pushes and refused requests) and the count after the request. A push
// on a full queue and a pop on an empty one are refused with ok low and
// leave the queue as it was. Words are cut to DATA_WIDTH bits when stored.
// ---------------------------------------------------------------------------
module double_ended_queue #(
	parameter int CAPACITY   = dq_pkg::DQ_CAPACITY,
	parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [dq_pkg::DQ_WORD_W-1:0]  push_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [dq_pkg::DQ_WORD_W-1:0]  pop_value,
	output logic [CNT_W-1:0]              count
);
	import dq_pkg::*;

	dq_cell_ctrl_t         cell_ctrl;
	logic [DATA_WIDTH-1:0] push_word;
	logic                  valid_w [CAPACITY];
	logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
	logic [DATA_WIDTH-1:0] ret_w   [CAPACITY];

	// stored words keep only DATA_WIDTH bits
	assign push_word = DATA_WIDTH'(push_value);

	dq_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.ok        (ok),
		.pop_value (pop_value),
		.count     (count),
		.head_data (data_w[0]),
		.ret_head  (ret_w[0]),
		.cell_ctrl (cell_ctrl)
	);

	// the cell chain; cell zero sees the incoming word as its predecessor,
	// the last cell sees an empty successor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  prev_valid;
		logic [DATA_WIDTH-1:0] prev_data;
		logic                  next_valid;
		logic [DATA_WIDTH-1:0] next_data;
		logic [DATA_WIDTH-1:0] ret_next;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_data  = push_word;
		end else begin : g_mid_prev
			assign prev_valid = valid_w[i-1];
			assign prev_data  = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_data  = '0;
			assign ret_next   = '0;
		end else begin : g_mid_next
			assign next_valid = valid_w[i+1];
			assign next_data  = data_w[i+1];
			assign ret_next   = ret_w[i+1];
		end

		dq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.push_word  (push_word),
			.prev_valid (prev_valid),
			.prev_data  (prev_data),
			.next_valid (next_valid),
			.next_data  (next_data),
			.ret_next   (ret_next),
			.valid      (valid_w[i]),
			.data       (data_w[i]),
			.ret        (ret_w[i])
		);
	end

endmodule

### src/dq_cell.sv
// ---------------------------------------------------------------------------
// dq_cell
// one storage cell of the deque chain, with its slot of the return path
// ---------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_cell #(
	parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dq_pkg::dq_cell_ctrl_t ctrl,
	input  logic [DATA_WIDTH-1:0] push_word,
	input  logic                  prev_valid,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic                  next_valid,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic [DATA_WIDTH-1:0] ret_next,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] ret
);
	import dq_pkg::*;

	logic                  valid_q;
	logic                  valid_d;
	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] ret_q;
	logic                  is_last;
	logic                  is_gap;

	// back end of the occupied run, and first free cell after it
	assign is_last = valid_q & ~next_valid;
	assign is_gap  = ~valid_q & prev_valid;

	always_comb begin
		case (ctrl.op)
			CELL_PUSH_FRONT: valid_d = prev_valid;
			CELL_PUSH_BACK:  valid_d = valid_q | is_gap;
			CELL_POP_FRONT:  valid_d = next_valid;
			CELL_POP_BACK:   valid_d = valid_q & ~is_last;
			default:         valid_d = valid_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH_FRONT: data_q <= prev_data;
			CELL_PUSH_BACK: begin
				if (is_gap) begin
					data_q <= push_word;
				end
			end
			CELL_POP_FRONT:  data_q <= next_data;
			default:         data_q <= data_q;
		endcase
	end

	// return path: the back word is launched here and walks to cell zero
	always_ff @(posedge clk) begin
		if (ctrl.op == CELL_POP_BACK) begin
			ret_q <= is_last ? data_q : '0;
		end else if (ctrl.ret_shift) begin
			ret_q <= ret_next;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign ret   = ret_q;

	`DQ_ASSERT_IMP(a_cell_packed, clk, arst_n, next_valid, valid_q, "deque cells not packed")
	`DQ_ASSERT_NXT(a_cell_push_front, clk, arst_n, (ctrl.op == CELL_PUSH_FRONT), (valid_q == $past(prev_valid)), "push front did not shift valid")
	`DQ_ASSERT_NXT(a_cell_pop_back, clk, arst_n, (ctrl.op == CELL_POP_BACK) && is_last, !valid_q, "pop back left tail cell valid")

endmodule

### src/dq_ctrl.sv
// ---------------------------------------------------------------------------
// dq_ctrl
// request decode, occupancy count, return sequencer and result register
// ---------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_ctrl #(
	parameter int CAPACITY   = dq_pkg::DQ_CAPACITY,
	parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH,
	localparam int CNT_W     = $clog2(CAPACITY + 1),
	localparam int IDX_W     = $clog2(CAPACITY)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          ok,
	output logic [dq_pkg::DQ_WORD_W-1:0]  pop_value,
	output logic [CNT_W-1:0]              count,
	input  logic [DATA_WIDTH-1:0]         head_data,
	input  logic [DATA_WIDTH-1:0]         ret_head,
	output dq_pkg::dq_cell_ctrl_t         cell_ctrl
);
	import dq_pkg::*;

	dq_state_t              state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [IDX_W-1:0]       ret_cnt_q, ret_cnt_d;
	logic                   out_valid_q;
	logic                   ok_q, ok_d;
	logic [DQ_WORD_W-1:0]   pop_q, pop_d;
	logic [CNT_W-1:0]       count_out_q;
	logic                   out_load;
	logic                   accept;
	logic                   is_full;
	logic                   is_empty;
	dq_req_t                req;

	assign req      = dq_req_t'(req_type);
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		state_d            = state_q;
		count_d            = count_q;
		ret_cnt_d          = ret_cnt_q;
		out_load           = 1'b0;
		ok_d               = 1'b0;
		pop_d              = '0;
		cell_ctrl.op       = CELL_HOLD;
		cell_ctrl.ret_shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							out_load = 1'b1;
							if (!is_full) begin
								cell_ctrl.op = (req == REQ_PUSH_FRONT) ? CELL_PUSH_FRONT
								                                       : CELL_PUSH_BACK;
								count_d = count_q + CNT_W'(1);
								ok_d    = 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							out_load = 1'b1;
							if (!is_empty) begin
								cell_ctrl.op = CELL_POP_FRONT;
								pop_d        = DQ_WORD_W'(head_data);
								count_d      = count_q - CNT_W'(1);
								ok_d         = 1'b1;
							end
						end
						REQ_POP_BACK: begin
							if (is_empty) begin
								out_load = 1'b1;
							end else begin
								cell_ctrl.op = CELL_POP_BACK;
								count_d      = count_q - CNT_W'(1);
								ret_cnt_d    = IDX_W'(count_q - CNT_W'(1));
								state_d      = ST_RETURN;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_RETURN: begin
				if (ret_cnt_q == '0) begin
					out_load = 1'b1;
					ok_d     = 1'b1;
					pop_d    = DQ_WORD_W'(ret_head);
					state_d  = ST_IDLE;
				end else begin
					cell_ctrl.ret_shift = 1'b1;
					ret_cnt_d           = ret_cnt_q - IDX_W'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ret_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ret_cnt_q <= ret_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q        <= ok_d;
			pop_q       <= pop_d;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign pop_value = pop_q;
	assign count     = count_out_q;

	`DQ_ASSERT_IMP(a_ret_no_result, clk, arst_n, (state_q == ST_RETURN), !out_valid_q, "result pending during return walk")
	`DQ_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, (count_q <= CNT_W'(CAPACITY)), "occupancy above capacity")
	`DQ_ASSERT_NXT(a_full_push_fails, clk, arst_n, accept && is_full && ((req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK)), out_valid_q && !ok_q && $stable(count_q), "push on full not refused")
	`DQ_ASSERT_NXT(a_empty_pop_zero, clk, arst_n, accept && is_empty && ((req == REQ_POP_FRONT) || (req == REQ_POP_BACK)), out_valid_q && !ok_q && (pop_q == '0), "pop on empty not refused")

endmodule

### bench/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_double_ended_queue
// self-checking bench for the fixed-capacity deque
// ---------------------------------------------------------------------------
// Requests are queued up front by an initial block: a short directed list
// (pops on empty, extreme words, a fill to capacity, pushes on full) and then
// runs of random requests biased toward pushing, popping or neither, so the
// queue swings between empty and full many times and the ring indices wrap.
// A clocked driver offers them at the falling edge, a shadow deque predicts
// each reply as its request is taken, and the monitor checks every reply
// field by field at the rising edge.
// ---------------------------------------------------------------------------
module tb_double_ended_queue;
	import dq_pkg::*;

	localparam int RANDOM_REQUESTS = 850;
	// cycles with no handshake on either side before giving up
	localparam int QUIET_LIMIT     = 2000;
	// long receiver hold-off, enough to back the request side up
	localparam int HOLD_CYCLES     = 120;
	// drain time after the last reply: longest pop back walk plus margin
	localparam int DRAIN_CYCLES    = 4 * DQ_CAPACITY;

	typedef struct {
		dq_req_t              kind;
		logic [DQ_WORD_W-1:0] word;
	} deque_request_t;

	typedef struct {
		logic                 ok;
		logic [DQ_WORD_W-1:0] pop_value;
		logic [4:0]           count;
	} deque_reply_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	dq_req_t              req_type   = REQ_PUSH_FRONT;
	logic [DQ_WORD_W-1:0] push_value = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic                 ok;
	logic [DQ_WORD_W-1:0] pop_value;
	logic [4:0]           count;

	double_ended_queue u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.pop_value  (pop_value),
		.count      (count)
	);

	always #2 clk = ~clk;

	// request stream and replies still owed by the block
	deque_request_t request_queue[$];
	deque_reply_t   reply_queue[$];

	// shadow ring: same capacity as the block
	logic [DQ_DATA_WIDTH-1:0] shadow_slots [DQ_CAPACITY];
	int                       shadow_front = 0;
	int                       shadow_back  = 0;
	int                       shadow_held  = 0;

	int   n_taken        = 0;
	int   total_requests = 0;
	int   n_errors       = 0;
	int   quiet_cycles   = 0;
	int   hold_left      = 0;
	bit   hold_done      = 1'b0;
	bit   req_fire       = 1'b0;
	deque_reply_t want;

	// apply one request to the shadow deque and return the reply it owes
	function automatic deque_reply_t shadow_apply(dq_req_t kind, logic [DQ_WORD_W-1:0] word);
		deque_reply_t r;
		r.ok        = 1'b0;
		r.pop_value = '0;
		case (kind)
			REQ_PUSH_FRONT: begin
				if (shadow_held < DQ_CAPACITY) begin
					shadow_front = (shadow_front + DQ_CAPACITY - 1) % DQ_CAPACITY;
					shadow_slots[shadow_front] = word[DQ_DATA_WIDTH-1:0];
					shadow_held++;
					r.ok = 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (shadow_held < DQ_CAPACITY) begin
					shadow_slots[shadow_back] = word[DQ_DATA_WIDTH-1:0];
					shadow_back = (shadow_back + 1) % DQ_CAPACITY;
					shadow_held++;
					r.ok = 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_held > 0) begin
					r.pop_value = DQ_WORD_W'(shadow_slots[shadow_front]);
					shadow_front = (shadow_front + 1) % DQ_CAPACITY;
					shadow_held--;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (shadow_held > 0) begin
					shadow_back = (shadow_back + DQ_CAPACITY - 1) % DQ_CAPACITY;
					r.pop_value = DQ_WORD_W'(shadow_slots[shadow_back]);
					shadow_held--;
					r.ok = 1'b1;
				end
			end
		endcase
		r.count = 5'(shadow_held);
		return r;
	endfunction

	// traffic shape: 0 sender light / receiver heavy idling, 1 swapped, 2 none
	function automatic int traffic_phase();
		if (n_taken < total_requests / 3)
			return 0;
		if (n_taken < (2 * total_requests) / 3)
			return 1;
		return 2;
	endfunction

	task automatic add_request(dq_req_t kind, logic [DQ_WORD_W-1:0] word);
		deque_request_t q;
		q.kind = kind;
		q.word = word;
		request_queue.push_back(q);
	endtask

	// word mix: corners, walking ones and plain random
	function automatic logic [DQ_WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return DQ_WORD_W'(1) << $urandom_range(0, DQ_WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// request driver: new request at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_fire)) begin
			if (request_queue.size() > 0 &&
				$urandom_range(0, 99) >= (traffic_phase() == 0 ? 29 :
				traffic_phase() == 1 ? 55 : 0)) begin
				in_valid   <= 1'b1;
				req_type   <= request_queue[0].kind;
				push_value <= request_queue[0].word;
				request_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// reply receiver: random stalls, plus one long hold-off late in the run
	always @(negedge clk) begin
		if (arst_n && !hold_done && traffic_phase() == 2 &&
			n_taken >= (5 * total_requests) / 6) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(0, 99) >= (traffic_phase() == 0 ? 55 :
				traffic_phase() == 1 ? 29 : 0);
		end
	end

	// monitor: check replies, record taken requests, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (reply_queue.size() == 0) begin
					$display("%0t: reply with none owed: ok %b pop_value %h count %0d",
						$time, ok, pop_value, count);
					n_errors++;
				end else begin
					want = reply_queue.pop_front();
					if (ok !== want.ok) begin
						$display("%0t: ok expected %b actual %b", $time, want.ok, ok);
						n_errors++;
					end
					if (pop_value !== want.pop_value) begin
						$display("%0t: pop_value expected %h actual %h",
							$time, want.pop_value, pop_value);
						n_errors++;
					end
					if (count !== want.count) begin
						$display("%0t: count expected %0d actual %0d",
							$time, want.count, count);
						n_errors++;
					end
				end
			end
			req_fire = in_valid && in_ready;
			if (req_fire) begin
				reply_queue.push_back(shadow_apply(req_type, push_value));
				n_taken++;
			end
			if (req_fire || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("double_ended_queue test failed");
				$finish;
			end
		end
	end

	initial begin
		int run_len;
		int push_pct;
		dq_req_t kind;

		// pops on an empty queue are refused
		add_request(REQ_POP_FRONT, 32'hDEAD_BEEF);
		add_request(REQ_POP_BACK, 32'h1234_5678);
		// extreme words through both ends
		add_request(REQ_PUSH_BACK, '1);
		add_request(REQ_PUSH_FRONT, '0);
		add_request(REQ_POP_BACK, '0);
		add_request(REQ_POP_FRONT, '1);
		// fill to capacity from both ends, front index wraps below zero
		for (int i = 0; i < DQ_CAPACITY; i++) begin
			if (i % 2 == 0)
				add_request(REQ_PUSH_FRONT, 32'h5555_5555 ^ DQ_WORD_W'(i));
			else
				add_request(REQ_PUSH_BACK, 32'hAAAA_AAAA ^ DQ_WORD_W'(i));
		end
		// pushes on a full queue are refused
		add_request(REQ_PUSH_FRONT, 32'hFFFF_0000);
		add_request(REQ_PUSH_BACK, 32'h0000_FFFF);
		// pop back at full depth: the longest return walk
		add_request(REQ_POP_BACK, '0);

		// random runs leaning to push, pop or neither
		total_requests = request_queue.size() + RANDOM_REQUESTS;
		while (request_queue.size() < total_requests) begin
			run_len = $urandom_range(4, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			repeat (run_len) begin
				if ($urandom_range(0, 99) < push_pct)
					kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else
					kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
				add_request(kind, pick_word());
			end
		end
		total_requests = request_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("double_ended_queue test passed");
		else
			$display("double_ended_queue test failed");
		$finish;
	end

endmodule
